// ----- rtl/frp_pkg.sv -----
// ----------------------------------------------------------------------------
// frp_pkg
// Shared types and constants for the framed record parser.
// ----------------------------------------------------------------------------
package frp_pkg;

    localparam int FRAME_DEPTH_DEF = 128;

    localparam int LEN_W   = 7;
    localparam int MAX_LEN = 99;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] START_RESET = 8'h02;
    localparam logic [7:0] END_RESET   = 8'h03;

    localparam logic REG_START = 1'b0;
    localparam logic REG_END   = 1'b1;

    localparam logic [2:0] ST_GROUP     = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_LEN_ERR   = 3'd2;
    localparam logic [2:0] ST_CKSUM_ERR = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       command;
        logic [LEN_W-1:0] len;
    } frp_job_t;

endpackage

// ----- rtl/frp_ram.sv -----
// ----------------------------------------------------------------------------
// frp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module frp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/frp_front.sv -----
// ----------------------------------------------------------------------------
// frp_front
// Byte intake: frame tracking, buffer writes, running checksum and length
// check. Each closed or dropped frame becomes one job for the back end.
// ----------------------------------------------------------------------------
module frp_front
    import frp_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     rx_byte,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [7:0]                     cfg_data,
    output logic                           ram_we,
    output logic [$clog2(FRAME_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                     ram_wdata,
    output logic                           q_push,
    output frp_job_t                       q_job,
    input  logic                           q_full,
    input  logic                           done
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);

    logic [7:0]    start_reg, start_next;
    logic [7:0]    end_reg, end_next;
    logic          in_frame_reg, in_frame_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    d1_reg, d1_next;
    logic [7:0]    d2_reg, d2_next;
    logic [7:0]    cmd_reg, cmd_next;
    logic [15:0]   sum_reg, sum_next;
    logic [7:0]    prev1_reg, prev1_next;
    logic [7:0]    prev2_reg, prev2_next;
    logic          lock_reg, lock_next;

    logic          acc;
    logic          is_start;
    logic          live;
    logic          ovf;
    logic          store;
    logic          closing;
    logic [CW-1:0] cnt_eff;
    logic [12:0]   d1x;
    logic [12:0]   lv;
    logic [12:0]   c_ext;
    logic          len_ok;
    logic [15:0]   dsum;
    logic [15:0]   csum;
    logic          ck_ok;

    assign in_stall = q_full || lock_reg;
    assign acc      = in_valid && !in_stall;
    assign is_start = (rx_byte == start_reg);
    assign cnt_eff  = is_start ? '0 : count_reg;
    assign live     = is_start || in_frame_reg;
    assign ovf      = (cnt_eff == CW'(FRAME_DEPTH));
    assign store    = acc && live && !ovf;
    assign closing  = store && (rx_byte == end_reg);

    assign ram_we    = store;
    assign ram_waddr = cnt_eff[AW-1:0];
    assign ram_wdata = rx_byte;
    assign q_push    = (acc && live && ovf) || closing;

    // frame check at the end byte (cnt_eff is its index)
    always_comb
    begin
        d1x    = {5'd0, d1_reg} - 13'd48;
        lv     = (d1x << 3) + (d1x << 1) + {5'd0, d2_reg} - 13'd48;
        c_ext  = 13'(cnt_eff);
        len_ok = (c_ext >= 13'd6) && !lv[12] && (lv <= 13'(MAX_LEN))
                 && (lv == c_ext - 13'd6);
        dsum   = sum_reg - {8'd0, prev1_reg} - {8'd0, prev2_reg};
        csum   = dsum + 16'd1;
        ck_ok  = (prev2_reg == ~csum[15:8]) && (prev1_reg == csum[7:0]);

        q_job = '0;
        if (ovf)
        begin
            q_job.status = ST_OVERFLOW;
        end
        else if (!len_ok)
        begin
            q_job.status = ST_LEN_ERR;
        end
        else if (!ck_ok)
        begin
            q_job.status = ST_CKSUM_ERR;
        end
        else if (lv[LEN_W-1:0] == '0)
        begin
            q_job.status  = ST_EMPTY;
            q_job.command = cmd_reg;
        end
        else
        begin
            q_job.status  = ST_GROUP;
            q_job.command = cmd_reg;
            q_job.len     = lv[LEN_W-1:0];
        end
    end

    always_comb
    begin
        start_next    = start_reg;
        end_next      = end_reg;
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        cmd_next      = cmd_reg;
        sum_next      = sum_reg;
        prev1_next    = prev1_reg;
        prev2_next    = prev2_reg;
        lock_next     = lock_reg;

        if (cfg_we)
        begin
            if (cfg_index == REG_START)
            begin
                start_next = cfg_data;
            end
            else
            begin
                end_next = cfg_data;
            end
        end

        if (acc && live)
        begin
            if (ovf)
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
            end
            else
            begin
                in_frame_next = !closing;
                count_next    = cnt_eff + CW'(1);
            end
        end

        if (store)
        begin
            if (cnt_eff == CW'(1))
            begin
                d1_next = rx_byte;
            end
            if (cnt_eff == CW'(2))
            begin
                d2_next = rx_byte;
            end
            if (cnt_eff == CW'(3))
            begin
                cmd_next = rx_byte;
                sum_next = {8'd0, rx_byte};
            end
            else if (cnt_eff > CW'(3))
            begin
                sum_next = sum_reg + {8'd0, rx_byte};
            end
            prev1_next = rx_byte;
            prev2_next = prev1_reg;
        end

        if (closing && (q_job.status == ST_GROUP))
        begin
            lock_next = 1'b1;
        end
        else if (done)
        begin
            lock_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= START_RESET;
            end_reg      <= END_RESET;
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            lock_reg     <= 1'b0;
        end
        else
        begin
            start_reg    <= start_next;
            end_reg      <= end_next;
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            lock_reg     <= lock_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        cmd_reg   <= cmd_next;
        sum_reg   <= sum_next;
        prev1_reg <= prev1_next;
        prev2_reg <= prev2_next;
    end

    // buffer must not change while the back end reads it
    assert property (@(posedge clk) disable iff (!rst_n) lock_reg |-> !ram_we)
        else $error("frp_front: buffer write while locked");

    assert property (@(posedge clk) disable iff (!rst_n)
                     (q_push && (q_job.status == ST_GROUP)) |=> lock_reg)
        else $error("frp_front: group job without lock");

endmodule

// ----- rtl/frp_queue.sv -----
// ----------------------------------------------------------------------------
// frp_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module frp_queue
    import frp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  frp_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     valid,
    output frp_job_t job
);

    frp_job_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign valid = (cnt_reg != 2'd0);
    assign job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("frp_queue: push while full");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
        else $error("frp_queue: pop while empty");

endmodule

// ----- rtl/frp_back.sv -----
// ----------------------------------------------------------------------------
// frp_back
// Job execution: reads 4-byte groups from the frame buffer and drives the
// result register.
// ----------------------------------------------------------------------------
module frp_back
    import frp_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  frp_job_t                       q_job,
    output logic                           q_pop,
    output logic [$clog2(FRAME_DEPTH)-1:0] ram_raddr,
    input  logic [7:0]                     ram_rdata,
    output logic                           done,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [7:0]                     command,
    output logic [7:0]                     group_id,
    output logic [7:0]                     value_first,
    output logic [7:0]                     value_second,
    output logic [7:0]                     value_third,
    output logic [1:0]                     value_count,
    output logic                           last
);

    localparam int AW = $clog2(FRAME_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CAP  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [1:0]       rd_cnt_reg, rd_cnt_next;
    logic             cap_vld_reg;
    logic [1:0]       cap_idx_reg;
    logic [7:0]       grp_reg [4];

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       status_reg, status_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       group_id_reg, group_id_next;
    logic [7:0]       val1_reg, val1_next;
    logic [7:0]       val2_reg, val2_next;
    logic [7:0]       val3_reg, val3_next;
    logic [1:0]       count_reg, count_next;
    logic             last_reg, last_next;

    logic             slot_free;
    logic             load;
    logic [1:0]       gcnt;
    logic             glast;

    assign slot_free = !out_valid_reg || !out_stall;
    assign ram_raddr = base_reg + AW'(rd_cnt_reg);
    assign glast     = (rem_reg <= LEN_W'(4));
    assign gcnt      = (rem_reg >= LEN_W'(4)) ? 2'd3 : 2'(rem_reg - LEN_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        base_next    = base_reg;
        rem_next     = rem_reg;
        rd_cnt_next  = rd_cnt_reg;
        q_pop        = 1'b0;
        done         = 1'b0;
        load         = 1'b0;
        status_next  = status_reg;
        command_next = command_reg;
        group_id_next = group_id_reg;
        val1_next    = val1_reg;
        val2_next    = val2_reg;
        val3_next    = val3_reg;
        count_next   = count_reg;
        last_next    = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_job.status == ST_GROUP)
                    begin
                        q_pop       = 1'b1;
                        cmd_next    = q_job.command;
                        base_next   = AW'(4);
                        rem_next    = q_job.len;
                        rd_cnt_next = 2'd0;
                        state_next  = S_READ;
                    end
                    else if (slot_free)
                    begin
                        q_pop         = 1'b1;
                        load          = 1'b1;
                        status_next   = q_job.status;
                        command_next  = q_job.command;
                        group_id_next = 8'd0;
                        val1_next     = 8'd0;
                        val2_next     = 8'd0;
                        val3_next     = 8'd0;
                        count_next    = 2'd0;
                        last_next     = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 2'd1;
                if (rd_cnt_reg == 2'd3)
                begin
                    state_next = S_CAP;
                end
            end
            S_CAP:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    load          = 1'b1;
                    status_next   = ST_GROUP;
                    command_next  = cmd_reg;
                    group_id_next = grp_reg[0] - ASCII_ZERO;
                    val1_next     = (gcnt >= 2'd1) ? grp_reg[1] : 8'd0;
                    val2_next     = (gcnt >= 2'd2) ? grp_reg[2] : 8'd0;
                    val3_next     = (gcnt == 2'd3) ? grp_reg[3] : 8'd0;
                    count_next    = gcnt;
                    last_next     = glast;
                    if (glast)
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rem_next    = rem_reg - LEN_W'(4);
                        base_next   = base_reg + AW'(4);
                        rd_cnt_next = 2'd0;
                        state_next  = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rem_reg       <= '0;
            rd_cnt_reg    <= 2'd0;
            cap_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            rd_cnt_reg    <= rd_cnt_next;
            cap_vld_reg   <= (state_reg == S_READ);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        base_reg     <= base_next;
        cap_idx_reg  <= rd_cnt_reg;
        status_reg   <= status_next;
        command_reg  <= command_next;
        group_id_reg <= group_id_next;
        val1_reg     <= val1_next;
        val2_reg     <= val2_next;
        val3_reg     <= val3_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
        if (cap_vld_reg)
        begin
            grp_reg[cap_idx_reg] <= ram_rdata;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign command      = command_reg;
    assign group_id     = group_id_reg;
    assign value_first  = val1_reg;
    assign value_second = val2_reg;
    assign value_third  = val3_reg;
    assign value_count  = count_reg;
    assign last         = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg != S_IDLE) |-> (rem_reg != '0))
        else $error("frp_back: group walk with no bytes left");

endmodule

// ----- rtl/framed_record_parser_core.sv -----
// ----------------------------------------------------------------------------
// framed_record_parser_core
// Framed record parser: buffers a frame, checks length and checksum at the
// end byte and emits one result per 4-byte data group or one status result.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   rx_byte
//   out      out_valid / out_stall status, command, group_id, value_first,
//                                  value_second, value_third, value_count, last
//   cfg      cfg_we                cfg_index, cfg_data
//
// One byte is taken per cycle while no group burst is in progress and the job queue is not full.
// A valid frame with N data bytes holds the input while its groups are walked:
// per group, 4 buffer reads on the single read port, then capture, then emit.
// Status results pass through a 2-entry job queue without blocking input.
// Reset is asynchronous; the frame buffer needs no clearing pass.
// out_stall holds the result register; input stalls when the queue is full.
// ----------------------------------------------------------------------------
module framed_record_parser_core
    import frp_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [7:0] command,
    output logic [7:0] group_id,
    output logic [7:0] value_first,
    output logic [7:0] value_second,
    output logic [7:0] value_third,
    output logic [1:0] value_count,
    output logic       last
);

    localparam int AW = $clog2(FRAME_DEPTH);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          q_push;
    frp_job_t      push_job;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    frp_job_t      q_job;
    logic          done;

    frp_front #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .q_push    (q_push),
        .q_job     (push_job),
        .q_full    (q_full),
        .done      (done)
    );

    frp_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    frp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .job      (q_job)
    );

    frp_back #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_job        (q_job),
        .q_pop        (q_pop),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .done         (done),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .command      (command),
        .group_id     (group_id),
        .value_first  (value_first),
        .value_second (value_second),
        .value_third  (value_third),
        .value_count  (value_count),
        .last         (last)
    );

endmodule
